### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define TFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define TFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/tfd_pkg.sv
package tfd_pkg;

    localparam int FMT_W = 5;

    // Source format codes
    localparam logic [FMT_W-1:0] FMT_A8R8G8B8 = 5'd0;
    localparam logic [FMT_W-1:0] FMT_X8R8G8B8 = 5'd1;
    localparam logic [FMT_W-1:0] FMT_R8G8B8   = 5'd2;
    localparam logic [FMT_W-1:0] FMT_A1R5G5B5 = 5'd3;
    localparam logic [FMT_W-1:0] FMT_X1R5G5B5 = 5'd4;
    localparam logic [FMT_W-1:0] FMT_A4R4G4B4 = 5'd5;
    localparam logic [FMT_W-1:0] FMT_X4R4G4B4 = 5'd6;
    localparam logic [FMT_W-1:0] FMT_R5G6B5   = 5'd7;
    localparam logic [FMT_W-1:0] FMT_R3G3B2   = 5'd8;
    localparam logic [FMT_W-1:0] FMT_A8R3G3B2 = 5'd9;
    localparam logic [FMT_W-1:0] FMT_A8       = 5'd10;
    localparam logic [FMT_W-1:0] FMT_L8       = 5'd11;
    localparam logic [FMT_W-1:0] FMT_A8L8     = 5'd12;
    localparam logic [FMT_W-1:0] FMT_A4L4     = 5'd13;
    localparam logic [FMT_W-1:0] FMT_DXT1     = 5'd14;
    localparam logic [FMT_W-1:0] FMT_DXT2     = 5'd15;
    localparam logic [FMT_W-1:0] FMT_DXT3     = 5'd16;
    localparam logic [FMT_W-1:0] FMT_DXT4     = 5'd17;
    localparam logic [FMT_W-1:0] FMT_DXT5     = 5'd18;

    // BC1 colour codes
    localparam logic [1:0] CCODE_C0 = 2'd0;
    localparam logic [1:0] CCODE_C1 = 2'd1;
    localparam logic [1:0] CCODE_C2 = 2'd2;
    localparam logic [1:0] CCODE_C3 = 2'd3;

    // BC3 alpha codes with a fixed meaning
    localparam logic [2:0] ACODE_A0   = 3'd0;
    localparam logic [2:0] ACODE_A1   = 3'd1;
    localparam logic [2:0] ACODE_ZERO = 3'd6;
    localparam logic [2:0] ACODE_FULL = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Reciprocal multipliers: exact for the operand ranges used below
    localparam logic [10:0] DIV3_MUL = 11'd683;   // / 3 as * 683 >> 11
    localparam logic [11:0] DIV5_MUL = 12'd3277;  // / 5 as * 3277 >> 14
    localparam logic [11:0] DIV7_MUL = 12'd2341;  // / 7 as * 2341 >> 14

    typedef struct packed {
        logic [63:0] color_word;
        logic [63:0] alpha_word;
        logic [3:0]  texel_index;
    } texel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } pix_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

    function automatic logic [7:0] widen2(input logic [1:0] v);
        return {v, v, v, v};
    endfunction

    // x <= 766
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(DIV3_MUL);
        return p[18:11];
    endfunction

    // x <= 1277
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(DIV5_MUL);
        return p[21:14];
    endfunction

    // x <= 1788
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(DIV7_MUL);
        return p[21:14];
    endfunction

endpackage

### rtl/tfd_ifs.sv
interface tfd_texel_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_word;
    logic [63:0] alpha_word;
    logic [3:0]  texel_index;

    modport source (output valid, output color_word, output alpha_word,
                    output texel_index, input ready);
    modport sink (input valid, input color_word, input alpha_word,
                  input texel_index, output ready);
endinterface

interface tfd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;

    modport source (output valid, output blue, output green, output red,
                    output alpha, input ready);
    modport sink (input valid, input blue, input green, input red,
                  input alpha, output ready);
endinterface

### rtl/tfd_dxt_decode.sv
module tfd_dxt_decode import tfd_pkg::*;
(
    input  logic [FMT_W-1:0] fmt,
    input  texel_t           tex,
    output pix_t             pix
);

    function automatic logic [7:0] color_pick(input logic [7:0] e0, input logic [7:0] e1,
                                              input logic [1:0] code, input logic four);
        logic [9:0] s2;
        logic [9:0] s3;
        logic [8:0] sh;
        logic [7:0] r;
        s2 = {1'b0, e0, 1'b0} + {2'b00, e1} + 10'd1;
        s3 = {2'b00, e0} + {1'b0, e1, 1'b0} + 10'd1;
        sh = {1'b0, e0} + {1'b0, e1} + 9'd1;
        case (code)
            CCODE_C0: r = e0;
            CCODE_C1: r = e1;
            CCODE_C2: r = four ? div3(s2) : sh[8:1];
            default:  r = four ? div3(s3) : 8'd0;
        endcase
        return r;
    endfunction

    logic [15:0] w0;
    logic [15:0] w1;
    logic [5:0]  cbit;
    logic [1:0]  ccode;
    logic        four;
    logic [7:0]  c0_b, c0_g, c0_r;
    logic [7:0]  c1_b, c1_g, c1_r;
    logic [3:0]  nib;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [5:0]  abit;
    logic [2:0]  acode;
    logic [2:0]  ai;
    logic [2:0]  w7;
    logic [2:0]  w5;
    logic [10:0] num7;
    logic [10:0] num5;
    logic [7:0]  interp_a;

    assign w0    = tex.color_word[15:0];
    assign w1    = tex.color_word[31:16];
    assign cbit  = {1'b1, tex.texel_index, 1'b0};   // 32 + 2t
    assign ccode = tex.color_word[cbit +: 2];
    assign four  = (fmt != FMT_DXT1) || (w0 > w1);

    assign c0_b = widen5(w0[4:0]);
    assign c0_g = widen6(w0[10:5]);
    assign c0_r = widen5(w0[15:11]);
    assign c1_b = widen5(w1[4:0]);
    assign c1_g = widen6(w1[10:5]);
    assign c1_r = widen5(w1[15:11]);

    assign nib = tex.alpha_word[{tex.texel_index, 2'b00} +: 4];

    assign a0    = tex.alpha_word[7:0];
    assign a1    = tex.alpha_word[15:8];
    assign abit  = 6'd16 + 6'(tex.texel_index) * 6'd3;
    assign acode = tex.alpha_word[abit +: 3];
    assign ai    = acode - 3'd1;
    assign w7    = 3'd7 - ai;
    assign w5    = 3'd5 - ai;
    assign num7  = 11'(w7) * 11'(a0) + 11'(ai) * 11'(a1) + 11'd3;
    assign num5  = 11'(w5) * 11'(a0) + 11'(ai) * 11'(a1) + 11'd2;

    always_comb
    begin
        if (acode == ACODE_A0)
        begin
            interp_a = a0;
        end
        else if (acode == ACODE_A1)
        begin
            interp_a = a1;
        end
        else if (a0 > a1)
        begin
            interp_a = div7(num7);
        end
        else if (acode == ACODE_ZERO)
        begin
            interp_a = 8'd0;
        end
        else if (acode == ACODE_FULL)
        begin
            interp_a = ALPHA_OPAQUE;
        end
        else
        begin
            interp_a = div5(num5);
        end
    end

    always_comb
    begin
        pix.blue  = color_pick(c0_b, c1_b, ccode, four);
        pix.green = color_pick(c0_g, c1_g, ccode, four);
        pix.red   = color_pick(c0_r, c1_r, ccode, four);
        if (fmt == FMT_DXT1)
        begin
            pix.alpha = (!four && ccode == CCODE_C3) ? 8'd0 : ALPHA_OPAQUE;
        end
        else if (fmt inside {FMT_DXT2, FMT_DXT3})
        begin
            pix.alpha = widen4(nib);
        end
        else
        begin
            pix.alpha = interp_a;
        end
    end

endmodule

### rtl/tfd_decode.sv
module tfd_decode import tfd_pkg::*;
(
    input  logic [FMT_W-1:0] fmt,
    input  texel_t           tex,
    output pix_t             pix
);

    pix_t        dxt_pix;
    logic [15:0] w;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;

    tfd_dxt_decode u_dxt
    (
        .fmt (fmt),
        .tex (tex),
        .pix (dxt_pix)
    );

    assign w  = tex.color_word[15:0];
    assign b0 = tex.color_word[7:0];
    assign b1 = tex.color_word[15:8];
    assign b2 = tex.color_word[23:16];
    assign b3 = tex.color_word[31:24];

    always_comb
    begin
        pix = '0;
        case (fmt)
            FMT_A8R8G8B8:
            begin
                pix = '{blue: b0, green: b1, red: b2, alpha: b3};
            end
            FMT_X8R8G8B8, FMT_R8G8B8:
            begin
                pix = '{blue: b0, green: b1, red: b2, alpha: ALPHA_OPAQUE};
            end
            FMT_A1R5G5B5, FMT_X1R5G5B5:
            begin
                pix.blue  = widen5(w[4:0]);
                pix.green = widen5(w[9:5]);
                pix.red   = widen5(w[14:10]);
                pix.alpha = (fmt == FMT_X1R5G5B5 || w[15]) ? ALPHA_OPAQUE : 8'd0;
            end
            FMT_A4R4G4B4, FMT_X4R4G4B4:
            begin
                pix.blue  = widen4(w[3:0]);
                pix.green = widen4(w[7:4]);
                pix.red   = widen4(w[11:8]);
                pix.alpha = (fmt == FMT_A4R4G4B4) ? widen4(w[15:12]) : ALPHA_OPAQUE;
            end
            FMT_R5G6B5:
            begin
                pix.blue  = widen5(w[4:0]);
                pix.green = widen6(w[10:5]);
                pix.red   = widen5(w[15:11]);
                pix.alpha = ALPHA_OPAQUE;
            end
            FMT_R3G3B2, FMT_A8R3G3B2:
            begin
                pix.blue  = widen2(b0[1:0]);
                pix.green = widen3(b0[4:2]);
                pix.red   = widen3(b0[7:5]);
                pix.alpha = (fmt == FMT_A8R3G3B2) ? b1 : ALPHA_OPAQUE;
            end
            FMT_A8:
            begin
                pix.alpha = b0;
            end
            FMT_L8:
            begin
                pix = '{blue: b0, green: b0, red: b0, alpha: ALPHA_OPAQUE};
            end
            FMT_A8L8:
            begin
                pix = '{blue: b0, green: b0, red: b0, alpha: b1};
            end
            FMT_A4L4:
            begin
                pix.blue  = widen4(b0[3:0]);
                pix.green = widen4(b0[3:0]);
                pix.red   = widen4(b0[3:0]);
                pix.alpha = widen4(b0[7:4]);
            end
            FMT_DXT1, FMT_DXT2, FMT_DXT3, FMT_DXT4, FMT_DXT5:
            begin
                pix = dxt_pix;
            end
            default:
            begin
                pix = '0;
            end
        endcase
    end

endmodule

### rtl/texel_format_decode.sv
// Texel format decoder: turns one raw texel (or one texel of a DXT1..DXT5
// 4x4 block) into 8-bit blue, green, red and alpha, following the format
// code held in the format register (written over cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle, which the block does
// not enforce; reset value is A8R8G8B8). The block accepts one texel per
// clock on tex_in and delivers one pixel per clock on pix_out while pix_out
// is not stalled; each texel passes through the input register, the decode
// logic and the result register before its pixel is offered on pix_out.
// The two registers form a pipeline whose ready chains back from pix_out, so
// a new texel is taken in any cycle in which the input register is empty or
// moves on into the result register; with pix_out stalled the block holds
// two texels and then drops tex_in.ready. Format codes 19 to 31 give an
// all-zero pixel.
module texel_format_decode import tfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [FMT_W-1:0] cfg_wr_data,
    tfd_texel_if.sink        tex_in,
    tfd_pixel_if.source      pix_out
);

    logic [FMT_W-1:0] fmt_reg;

    // Input register
    texel_t tex_reg;
    logic   in_valid_reg;
    logic   in_valid_next;

    // Result register
    pix_t   pix_reg;
    pix_t   pix_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    logic   out_adv;
    logic   in_fire;

    // Advance the result register whenever it is empty or being drained.
    assign out_adv      = !out_valid_reg || pix_out.ready;
    // Take a new texel whenever the input register is empty or moves on.
    assign tex_in.ready = !in_valid_reg || out_adv;
    assign in_fire      = tex_in.valid && tex_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (tex_in.ready)
        begin
            in_valid_next = tex_in.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_adv)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // Single-pass decode between the two registers.
    tfd_decode u_decode
    (
        .fmt (fmt_reg),
        .tex (tex_reg),
        .pix (pix_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_A8R8G8B8;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fmt_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on a transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tex_reg.color_word  <= tex_in.color_word;
            tex_reg.alpha_word  <= tex_in.alpha_word;
            tex_reg.texel_index <= tex_in.texel_index;
        end
        if (out_adv && in_valid_reg)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.blue  = pix_reg.blue;
    assign pix_out.green = pix_reg.green;
    assign pix_out.red   = pix_reg.red;
    assign pix_out.alpha = pix_reg.alpha;

endmodule

### rtl/tfd_checker.sv
`include "assert_macros.svh"

module tfd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pix
);

    // Nothing is pending right out of reset.
    `TFD_ASSERT_ALWAYS(a_out_empty_after_reset, clk, $rose(rst_n) |-> !out_valid, "result valid right after reset")

    // Input back-pressure only when a result is stuck at the output.
    `TFD_ASSERT(a_stall_only_when_full, clk, rst_n, !in_ready |-> out_valid, "input stalled with empty output")

    // A new result follows an input transfer through the input and result registers.
    `TFD_ASSERT(a_result_has_source, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a matching input transfer")

    // Hold a stalled result.
    `TFD_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_pix)), "stalled result changed")

endmodule

bind texel_format_decode tfd_checker u_tfd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tex_in.valid),
    .in_ready  (tex_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pix   ({pix_out.blue, pix_out.green, pix_out.red, pix_out.alpha})
);

### tb/tb_texel_format_decode.sv
module tb_texel_format_decode;
    import tfd_pkg::*;

    // Percentage of cycles in which each side sits out at random
    localparam int IDLE_PCT    = 11;
    // Length of the long sink hold-off, in cycles
    localparam int HOLD_CYCLES = 80;
    // Cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    // Cycles to let the two pipeline stages drain after the last pixel
    localparam int DRAIN_CYCLES = 8;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [FMT_W-1:0] cfg_wr_data;

    tfd_texel_if tex_if ();
    tfd_pixel_if pix_if ();

    texel_format_decode dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tex_in      (tex_if),
        .pix_out     (pix_if)
    );

    // Testbench copy of the format register; changed only while the block is idle
    logic [FMT_W-1:0] active_fmt;

    texel_t pending_texels[$];   // texels waiting to be offered
    pix_t   expected_pixels[$];  // decoded pixels not yet seen on the output

    int texels_queued;
    int texels_accepted;
    int pixels_checked;
    int mismatches;
    int phases_run;

    // Traffic shaping knobs, set by the stimulus process with nonblocking writes
    bit src_pause;      // stop offering texels
    bit steady;         // neither side idles
    bit sink_hold_req;  // ask the sink for one long hold-off
    bit sink_hold_armed;
    int sink_hold_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Widen narrow channels to 8 bits by repeating the top bits
    function automatic int expand2(input int v);
        return ((v << 6) | (v << 4) | (v << 2) | v) & 255;
    endfunction

    function automatic int expand3(input int v);
        return ((v << 5) | (v << 2) | (v >> 1)) & 255;
    endfunction

    function automatic int expand4(input int v);
        return ((v << 4) | v) & 255;
    endfunction

    function automatic int expand5(input int v);
        return ((v << 3) | (v >> 2)) & 255;
    endfunction

    function automatic int expand6(input int v);
        return ((v << 2) | (v >> 4)) & 255;
    endfunction

    // Channel k (0 blue, 1 green, 2 red) of a 5:6:5 word
    function automatic int ch565(input int w, input int k);
        case (k)
            0: return expand5(w & 31);
            1: return expand6((w >> 5) & 63);
            default: return expand5((w >> 11) & 31);
        endcase
    endfunction

    function automatic pix_t predict_pixel(input logic [FMT_W-1:0] fmt,
                                           input logic [63:0] cw,
                                           input logic [63:0] aw,
                                           input logic [3:0] idx);
        int   ch[4];
        int   e0[3];
        int   e1[3];
        int   code;
        int   acode;
        int   a0;
        int   a1;
        int   step;
        logic [15:0] w0;
        logic [15:0] w1;
        bit   four;
        pix_t px;
        ch = '{0, 0, 0, 0};
        w0 = cw[15:0];
        w1 = cw[31:16];
        case (fmt)
            FMT_A8R8G8B8: ch = '{cw[7:0], cw[15:8], cw[23:16], cw[31:24]};
            FMT_X8R8G8B8, FMT_R8G8B8: ch = '{cw[7:0], cw[15:8], cw[23:16], 255};
            FMT_A1R5G5B5, FMT_X1R5G5B5:
            begin
                ch[0] = expand5(w0[4:0]);
                ch[1] = expand5(w0[9:5]);
                ch[2] = expand5(w0[14:10]);
                ch[3] = (fmt == FMT_X1R5G5B5 || w0[15]) ? 255 : 0;
            end
            FMT_A4R4G4B4, FMT_X4R4G4B4:
            begin
                ch[0] = expand4(w0[3:0]);
                ch[1] = expand4(w0[7:4]);
                ch[2] = expand4(w0[11:8]);
                ch[3] = (fmt == FMT_A4R4G4B4) ? expand4(w0[15:12]) : 255;
            end
            FMT_R5G6B5: ch = '{ch565(w0, 0), ch565(w0, 1), ch565(w0, 2), 255};
            FMT_R3G3B2, FMT_A8R3G3B2:
            begin
                ch[0] = expand2(cw[1:0]);
                ch[1] = expand3(cw[4:2]);
                ch[2] = expand3(cw[7:5]);
                ch[3] = (fmt == FMT_A8R3G3B2) ? int'(cw[15:8]) : 255;
            end
            FMT_A8: ch[3] = cw[7:0];
            FMT_L8: ch = '{cw[7:0], cw[7:0], cw[7:0], 255};
            FMT_A8L8: ch = '{cw[7:0], cw[7:0], cw[7:0], cw[15:8]};
            FMT_A4L4:
            begin
                ch[0] = expand4(cw[3:0]);
                ch[1] = ch[0];
                ch[2] = ch[0];
                ch[3] = expand4(cw[7:4]);
            end
            FMT_DXT1, FMT_DXT2, FMT_DXT3, FMT_DXT4, FMT_DXT5:
            begin
                code = cw[32 + 2*idx +: 2];
                // Three-colour mode only for DXT1 with color0 <= color1
                four = (fmt != FMT_DXT1) || (w0 > w1);
                for (int k = 0; k < 3; k++)
                begin
                    e0[k] = ch565(w0, k);
                    e1[k] = ch565(w1, k);
                    case (code)
                        CCODE_C0: ch[k] = e0[k];
                        CCODE_C1: ch[k] = e1[k];
                        CCODE_C2: ch[k] = four ? (2*e0[k] + e1[k] + 1) / 3
                                               : (e0[k] + e1[k] + 1) / 2;
                        default:  ch[k] = four ? (e0[k] + 2*e1[k] + 1) / 3 : 0;
                    endcase
                end
                if (fmt == FMT_DXT1)
                    ch[3] = (!four && code == CCODE_C3) ? 0 : 255;
                else if (fmt == FMT_DXT2 || fmt == FMT_DXT3)
                    ch[3] = int'(aw[4*idx +: 4]) * 17;
                else
                begin
                    a0    = aw[7:0];
                    a1    = aw[15:8];
                    acode = aw[16 + 3*idx +: 3];
                    step  = acode - 1;
                    if (acode == ACODE_A0)
                        ch[3] = a0;
                    else if (acode == ACODE_A1)
                        ch[3] = a1;
                    else if (a0 > a1)
                        ch[3] = ((7 - step)*a0 + step*a1 + 3) / 7;
                    else if (acode == ACODE_ZERO)
                        ch[3] = 0;
                    else if (acode == ACODE_FULL)
                        ch[3] = 255;
                    else
                        ch[3] = ((5 - step)*a0 + step*a1 + 2) / 5;
                end
            end
            default: ;  // unknown codes decode to all zeros
        endcase
        px.blue  = ch[0][7:0];
        px.green = ch[1][7:0];
        px.red   = ch[2][7:0];
        px.alpha = ch[3][7:0];
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Texel driver: offer queued texels, predict on each transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : texel_driver
        texel_t nxt;
        if (!rst_n)
        begin
            tex_if.valid <= 1'b0;
        end
        else
        begin
            // Predict with the format in force when the texel is taken in
            if (tex_if.valid && tex_if.ready)
            begin
                expected_pixels.push_back(predict_pixel(active_fmt, tex_if.color_word,
                                                        tex_if.alpha_word,
                                                        tex_if.texel_index));
                texels_accepted++;
            end
            // Hold the current texel until it transfers; otherwise load the next one
            if (!tex_if.valid || tex_if.ready)
            begin
                if (pending_texels.size() != 0 && !src_pause &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_texels.pop_front();
                    tex_if.color_word  <= nxt.color_word;
                    tex_if.alpha_word  <= nxt.alpha_word;
                    tex_if.texel_index <= nxt.texel_index;
                    tex_if.valid       <= 1'b1;
                end
                else
                begin
                    tex_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel monitor: check each transfer against the oldest prediction,
    // and drive ready with random idling plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : pixel_monitor
        pix_t want;
        pix_t got;
        if (!rst_n)
        begin
            pix_if.ready    <= 1'b0;
            sink_hold_left  <= 0;
            sink_hold_armed <= 1'b0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                got.blue  = pix_if.blue;
                got.green = pix_if.green;
                got.red   = pix_if.red;
                got.alpha = pix_if.alpha;
                pixels_checked++;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("pixel %0d arrived with nothing predicted: b=%02h g=%02h r=%02h a=%02h",
                                 pixels_checked, got.blue, got.green, got.red, got.alpha);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.blue !== want.blue || got.green !== want.green ||
                        got.red !== want.red || got.alpha !== want.alpha)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("pixel %0d: expected b=%02h g=%02h r=%02h a=%02h, got b=%02h g=%02h r=%02h a=%02h",
                                     pixels_checked, want.blue, want.green, want.red,
                                     want.alpha, got.blue, got.green, got.red, got.alpha);
                    end
                end
            end
            // Arm the long hold-off once per request, then count it down
            if (sink_hold_req && !sink_hold_armed)
            begin
                sink_hold_armed <= 1'b1;
                sink_hold_left  <= HOLD_CYCLES;
                pix_if.ready    <= 1'b0;
            end
            else
            begin
                if (!sink_hold_req)
                    sink_hold_armed <= 1'b0;
                if (sink_hold_left != 0)
                begin
                    sink_hold_left <= sink_hold_left - 1;
                    pix_if.ready   <= 1'b0;
                end
                else
                begin
                    pix_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when no transfer happens for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (tex_if.valid && tex_if.ready) || (pix_if.valid && pix_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, %0d pixels still predicted",
                 QUIET_LIMIT, expected_pixels.size());
        $display("tb_texel_format_decode failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_texel(input logic [63:0] cw, input logic [63:0] aw,
                             input logic [3:0] idx);
        texel_t t;
        t.color_word  = cw;
        t.alpha_word  = aw;
        t.texel_index = idx;
        pending_texels.push_back(t);
        texels_queued++;
    endtask

    // Write the format register; only called with the block idle
    task automatic load_format(input int fmt);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= FMT_W'(fmt);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        active_fmt  <= FMT_W'(fmt);
    endtask

    // Wait until every queued texel has transferred and every pixel checked
    task automatic wait_idle();
        do
            @(posedge clk);
        while (texels_accepted != texels_queued || expected_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Stop the sender mid-stream until every predicted pixel has come back
    task automatic pause_until_drained();
        while (pending_texels.size() > 15)
            @(posedge clk);
        src_pause <= 1'b1;
        @(posedge clk);
        do
            @(posedge clk);
        while (tex_if.valid || expected_pixels.size() != 0);
        src_pause <= 1'b0;
    endtask

    // Corner texels for one format: extremes, alpha bit, DXT colour and alpha modes
    task automatic queue_directed(input int fmt);
        case (fmt)
            FMT_A8R8G8B8:
            begin
                add_texel('0, '0, 4'd0);
                add_texel('1, '1, 4'd15);
                add_texel(64'h0000_0000_4433_2211, '0, 4'd0);
            end
            FMT_A1R5G5B5:
            begin
                add_texel(64'h0000_0000_0000_8000, '0, 4'd0);
                add_texel(64'h0000_0000_0000_7FFF, '0, 4'd0);
            end
            FMT_A8: add_texel(64'h1234_5678_9ABC_DEFF, '0, 4'd0);
            FMT_DXT1:
            begin
                // four-colour block, codes 2 and 3
                add_texel(64'h0000_000E_0000_FFFF, '0, 4'd0);
                add_texel(64'h0000_000E_0000_FFFF, '0, 4'd1);
                // three-colour block, midpoint and transparent black
                add_texel(64'h0000_000E_FFFF_0000, '0, 4'd0);
                add_texel(64'h0000_000E_FFFF_0000, '0, 4'd1);
                // equal endpoints fall into three-colour mode
                add_texel(64'hC000_0000_1234_1234, '0, 4'd15);
            end
            FMT_DXT2: add_texel(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'd7);
            FMT_DXT3:
            begin
                add_texel(64'h0123_4567_89AB_CDEF, '1, 4'd15);
                add_texel(64'h0123_4567_89AB_CDEF, '0, 4'd0);
            end
            FMT_DXT4: add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0001_8000_0AC8, 4'd5);
            FMT_DXT5:
            begin
                // alpha0 <= alpha1: fixed zero, fixed full and the five-step ramp
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0B3E_C80A, 4'd0);
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0B3E_C80A, 4'd1);
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0B3E_C80A, 4'd2);
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0B3E_C80A, 4'd3);
                // alpha0 > alpha1: seven-step ramp
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0001_8000_0AC8, 4'd5);
                // equal endpoints
                add_texel(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0005_8080, 4'd0);
            end
            default:
            begin
                if (fmt > FMT_DXT5)
                    add_texel('1, '1, 4'd15);
            end
        endcase
    endtask

    // Random texels; bias DXT blocks so equal endpoints show up now and then
    task automatic queue_random(input int fmt, input int n);
        logic [63:0] cw;
        logic [63:0] aw;
        repeat (n)
        begin
            cw = {$urandom, $urandom};
            aw = {$urandom, $urandom};
            case ($urandom_range(15))
                0: cw = '0;
                1: cw = '1;
                default: ;
            endcase
            if (fmt >= FMT_DXT1 && fmt <= FMT_DXT5 && $urandom_range(7) == 0)
                cw[31:16] = cw[15:0];
            if ((fmt == FMT_DXT4 || fmt == FMT_DXT5) && $urandom_range(7) == 0)
                aw[15:8] = aw[7:0];
            add_texel(cw, aw, 4'($urandom_range(15)));
        end
    endtask

    initial
    begin : stimulus
        int sweep[$];
        // Drive every input to a known value from time zero
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        tex_if.valid       = 1'b0;
        tex_if.color_word  = '0;
        tex_if.alpha_word  = '0;
        tex_if.texel_index = '0;
        pix_if.ready       = 1'b0;
        active_fmt         = FMT_A8R8G8B8;
        src_pause          = 1'b0;
        steady             = 1'b0;
        sink_hold_req      = 1'b0;
        texels_queued      = 0;
        texels_accepted    = 0;
        pixels_checked     = 0;
        mismatches         = 0;
        phases_run         = 0;

        // Every known format in order, then the extremes, then random codes
        for (int f = 0; f <= FMT_DXT5; f++)
            sweep.push_back(f);
        sweep.push_back(31);
        sweep.push_back(FMT_DXT5 + 1);
        sweep.push_back(FMT_A8R8G8B8);
        sweep.push_back(FMT_DXT5);
        repeat (8) sweep.push_back($urandom_range(31));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (sweep[p])
        begin
            // The first phase runs on the reset value of the format register
            if (p != 0)
                load_format(sweep[p]);
            if (p == 4)
                sink_hold_req <= 1'b1;
            if (p == 6)
                steady <= 1'b1;
            if (p < 20)
                queue_directed(sweep[p]);
            queue_random(sweep[p], (p == 6) ? 60 : 30);
            if (p == FMT_DXT1)
                pause_until_drained();
            wait_idle();
            sink_hold_req <= 1'b0;
            steady        <= 1'b0;
            phases_run++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d texels in, %0d pixels checked over %0d format settings (all 19 formats,",
                 texels_accepted, pixels_checked, phases_run);
        $display("unknown codes, both DXT colour and alpha modes); %0d mismatches", mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb_texel_format_decode passed");
        else
            $display("tb_texel_format_decode failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tfd_pkg.sv
rtl/tfd_ifs.sv
rtl/tfd_dxt_decode.sv
rtl/tfd_decode.sv
rtl/texel_format_decode.sv
rtl/tfd_checker.sv
tb/tb_texel_format_decode.sv
